>>> sv/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants, opcodes and cell control types for the positional list.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);
    localparam logic [4:0]       NO_INDEX  = 5'h1F;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE_AT  = 3'd1,
        OP_REMOVE_VAL = 3'd2,
        OP_REPLACE    = 3'd3,
        OP_FIND       = 3'd4,
        OP_READ       = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_FROM_LEFT,
        CMD_FROM_RIGHT,
        CMD_LOAD
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      capture;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

>>> sv/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell
// One list slot: holds an entry, shifts to or from its neighbours, loads a
// new value and registers an equality compare against the search key.
// ----------------------------------------------------------------------------
module plc_cell (
    input  logic                           i_clk,
    input  plc_pkg::t_cell_ctrl            i_ctrl,
    input  logic [plc_pkg::DATA_W-1:0]     i_left,
    input  logic [plc_pkg::DATA_W-1:0]     i_right,
    input  logic [plc_pkg::DATA_W-1:0]     i_elem,
    output logic [plc_pkg::DATA_W-1:0]     o_value,
    output logic                           o_match
);

    logic [plc_pkg::DATA_W-1:0] r_value;
    logic                       r_match;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            plc_pkg::CMD_FROM_LEFT:  r_value <= i_left;
            plc_pkg::CMD_FROM_RIGHT: r_value <= i_right;
            plc_pkg::CMD_LOAD:       r_value <= i_elem;
            default:                 r_value <= r_value;
        endcase
        if (i_ctrl.capture) begin
            r_match <= (r_value == i_elem);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

>>> sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each request passes through an accept and an execute state. In the accept
// cycle every cell compares its entry with the request element and registers
// the match; in the execute cycle the registered match vector is
// priority-encoded and every cell shifts, loads or holds at once to apply the
// operation. The result goes to an output register, so the next request is
// accepted while it waits; no request is taken during the execute cycle. The
// execute cycle waits only when the output register still holds an untaken
// result. Entries above the count are never read.
module positional_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // opcode[2:0], position[7:3], element[39:8]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // ok[0], data_out[32:1], index_out[37:33], count_out[42:38], is_empty[43], zero pad
    output logic [47:0] o_m_axis_tdata
);

    localparam int N = plc_pkg::CAPACITY;

    plc_pkg::t_state                 r_state, n_state;
    logic [2:0]                      r_op;
    logic [4:0]                      r_pos;
    logic [plc_pkg::DATA_W-1:0]      r_elem;
    logic [plc_pkg::CNT_W-1:0]       r_count, n_count;

    logic                            r_out_valid;
    logic [47:0]                     r_out_data;

    plc_pkg::t_cell_ctrl             w_ctrl [N];
    logic [plc_pkg::DATA_W-1:0]      w_value [N];
    logic [N-1:0]                    w_match;
    logic [plc_pkg::DATA_W-1:0]      w_cell_elem;

    logic                            w_accept;
    logic                            w_slot_free;
    logic                            w_load_out;
    logic [N-1:0]                    w_hits;
    logic                            w_found;
    logic [plc_pkg::IDX_W-1:0]       w_first;
    logic [plc_pkg::IDX_W-1:0]       w_last;
    logic                            w_pos_valid;
    logic [plc_pkg::IDX_W-1:0]       w_pos_idx;
    logic [plc_pkg::IDX_W-1:0]       w_shift_at;

    logic                            w_ok;
    logic [plc_pkg::DATA_W-1:0]      w_data;
    logic [4:0]                      w_index;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_pos_valid = (r_pos < r_count);
    assign w_pos_idx   = r_pos[plc_pkg::IDX_W-1:0];
    // compare key comes straight from the request while idle
    assign w_cell_elem = (r_state == plc_pkg::S_IDLE) ? i_s_axis_tdata[39:8] : r_elem;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [plc_pkg::DATA_W-1:0] w_left;
            logic [plc_pkg::DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_value[g-1];
            end
            if (g == N - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner_r
                assign w_right = w_value[g+1];
            end
            plc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[g]),
                .i_left  (w_left),
                .i_right (w_right),
                .i_elem  (w_cell_elem),
                .o_value (w_value[g]),
                .o_match (w_match[g])
            );
            assign w_hits[g] = w_match[g] && (plc_pkg::CNT_W'(g) < r_count);
        end
    endgenerate

    // first and last hit over the registered match vector
    always_comb begin
        w_first = '0;
        w_last  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (w_hits[i]) begin
                w_first = plc_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < N; i++) begin
            if (w_hits[i]) begin
                w_last = plc_pkg::IDX_W'(i);
            end
        end
    end
    assign w_found    = |w_hits;
    assign w_shift_at = (r_op == plc_pkg::OP_REMOVE_VAL) ? w_last : w_pos_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        o_s_axis_tready = 1'b0;
        w_load_out      = 1'b0;
        w_ok            = 1'b0;
        w_data          = '0;
        w_index         = plc_pkg::NO_INDEX;
        for (int i = 0; i < N; i++) begin
            w_ctrl[i] = '{cmd: plc_pkg::CMD_HOLD, capture: 1'b0};
        end
        case (r_state)
            plc_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    for (int i = 0; i < N; i++) begin
                        w_ctrl[i].capture = 1'b1;
                    end
                    n_state = plc_pkg::S_EXEC;
                end
            end
            plc_pkg::S_EXEC: begin
                if (w_slot_free) begin
                    w_load_out = 1'b1;
                    n_state    = plc_pkg::S_IDLE;
                    case (r_op)
                        plc_pkg::OP_INSERT: begin
                            if (r_pos <= r_count && r_count < plc_pkg::CAP_COUNT) begin
                                w_ok    = 1'b1;
                                n_count = r_count + plc_pkg::CNT_W'(1);
                                for (int i = 0; i < N; i++) begin
                                    if (plc_pkg::CNT_W'(i) > r_pos) begin
                                        w_ctrl[i].cmd = plc_pkg::CMD_FROM_LEFT;
                                    end else if (plc_pkg::CNT_W'(i) == r_pos) begin
                                        w_ctrl[i].cmd = plc_pkg::CMD_LOAD;
                                    end
                                end
                            end
                        end
                        plc_pkg::OP_REMOVE_AT, plc_pkg::OP_REMOVE_VAL: begin
                            if (r_op == plc_pkg::OP_REMOVE_AT) begin
                                w_ok = w_pos_valid;
                                if (w_pos_valid) begin
                                    w_data = w_value[w_pos_idx];
                                end
                            end else begin
                                w_ok = w_found;
                                if (w_found) begin
                                    w_index = {1'b0, w_last};
                                end
                            end
                            if (w_ok) begin
                                n_count = r_count - plc_pkg::CNT_W'(1);
                                for (int i = 0; i < N; i++) begin
                                    if (plc_pkg::IDX_W'(i) >= w_shift_at) begin
                                        w_ctrl[i].cmd = plc_pkg::CMD_FROM_RIGHT;
                                    end
                                end
                            end
                        end
                        plc_pkg::OP_REPLACE: begin
                            if (w_pos_valid) begin
                                w_ok = 1'b1;
                                w_ctrl[w_pos_idx].cmd = plc_pkg::CMD_LOAD;
                            end
                        end
                        plc_pkg::OP_FIND: begin
                            if (w_found) begin
                                w_ok    = 1'b1;
                                w_index = {1'b0, w_first};
                            end
                        end
                        plc_pkg::OP_READ: begin
                            if (w_pos_valid) begin
                                w_ok   = 1'b1;
                                w_data = w_value[w_pos_idx];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = plc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_axis_tdata[2:0];
            r_pos  <= i_s_axis_tdata[7:3];
            r_elem <= i_s_axis_tdata[39:8];
        end
        if (w_load_out) begin
            r_out_data <= {4'b0000, (n_count == '0), n_count, w_index, w_data, w_ok};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    property p_count_bounded;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plc_pkg::CAP_COUNT;
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("list count above capacity");

    property p_count_step;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plc_pkg::S_IDLE) |=> (r_count == $past(r_count));
    endproperty
    a_count_step: assert property (p_count_step)
        else $error("count changed outside the execute cycle");

    property p_exec_delivers;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plc_pkg::S_EXEC && w_slot_free) |=>
            (r_state == plc_pkg::S_IDLE && r_out_valid);
    endproperty
    a_exec_delivers: assert property (p_exec_delivers)
        else $error("execute cycle did not load a result");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine: requests go in on the
// slave stream with random gaps, a list scoreboard works out each result as
// the request is taken, and every result on the master stream is compared
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------

typedef struct {
    logic        ok;
    logic [31:0] value;
    logic [4:0]  index;
    logic [4:0]  count;
    logic        empty;
} t_list_result;

class list_scoreboard;
    logic [31:0]  cells [plc_pkg::CAPACITY];
    int unsigned  fill;
    t_list_result pending_q [$];
    int unsigned  errors;
    int unsigned  requests;
    int unsigned  checked;
    int unsigned  succeeded;
    int unsigned  full_hits;
    int unsigned  op_seen [8];

    function new();
        fill      = 0;
        errors    = 0;
        requests  = 0;
        checked   = 0;
        succeeded = 0;
        full_hits = 0;
        foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function int unsigned list_count();
        return fill;
    endfunction

    function int unsigned pending();
        return pending_q.size();
    endfunction

    // close the gap left at position at
    function void remove_cell(int unsigned at);
        int unsigned i;
        for (i = at; i + 1 < fill; i++) cells[i] = cells[i + 1];
        fill--;
    endfunction

    function t_list_result apply_list_op(logic [2:0] op, logic [4:0] pos,
                                         logic [31:0] elem);
        t_list_result r;
        int           hit;
        int unsigned  i;
        r.ok    = 1'b0;
        r.value = '0;
        r.index = plc_pkg::NO_INDEX;
        case (plc_pkg::t_opcode'(op))
            plc_pkg::OP_INSERT: begin
                if (pos <= fill && fill < plc_pkg::CAPACITY) begin
                    for (i = fill; i > pos; i--) cells[i] = cells[i - 1];
                    cells[pos] = elem;
                    fill++;
                    r.ok = 1'b1;
                end else if (fill == plc_pkg::CAPACITY) begin
                    full_hits++;
                end
            end
            plc_pkg::OP_REMOVE_AT: begin
                if (pos < fill) begin
                    r.value = cells[pos];
                    remove_cell(pos);
                    r.ok = 1'b1;
                end
            end
            plc_pkg::OP_REMOVE_VAL: begin
                // last matching entry wins
                hit = -1;
                for (i = 0; i < fill; i++) if (cells[i] == elem) hit = i;
                if (hit >= 0) begin
                    remove_cell(hit);
                    r.index = hit[4:0];
                    r.ok    = 1'b1;
                end
            end
            plc_pkg::OP_REPLACE: begin
                if (pos < fill) begin
                    cells[pos] = elem;
                    r.ok = 1'b1;
                end
            end
            plc_pkg::OP_FIND: begin
                // first matching entry wins
                for (i = 0; i < fill; i++) begin
                    if (!r.ok && cells[i] == elem) begin
                        r.index = i[4:0];
                        r.ok    = 1'b1;
                    end
                end
            end
            plc_pkg::OP_READ: begin
                if (pos < fill) begin
                    r.value = cells[pos];
                    r.ok    = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = fill[4:0];
        r.empty = (fill == 0);
        return r;
    endfunction

    function void note_request(logic [39:0] d);
        requests++;
        op_seen[d[2:0]]++;
        pending_q.push_back(apply_list_op(d[2:0], d[7:3], d[39:8]));
    endfunction

    function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name,
                     exp_v, act_v);
        end
    endfunction

    function void check_result(logic [47:0] d);
        t_list_result e;
        if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $realtime, d);
        end else begin
            e = pending_q.pop_front();
            checked++;
            if (e.ok) succeeded++;
            report_field("ok",        32'(e.ok),    32'(d[0]));
            report_field("data_out",  e.value,      d[32:1]);
            report_field("index_out", 32'(e.index), 32'(d[37:33]));
            report_field("count_out", 32'(e.count), 32'(d[42:38]));
            report_field("is_empty",  32'(e.empty), 32'(d[43]));
        end
    endfunction
endclass

module tb_top;

    localparam logic [2:0] OP_SPARE_6  = 3'd6;
    localparam logic [2:0] OP_SPARE_7  = 3'd7;
    localparam int         HOLD_CYCLES = 300;
    localparam int         STALL_LIMIT = 3000;
    localparam int         PHASES      = 19;
    localparam int         PHASE_LEN   = 100;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [47:0] m_data;

    bit          started     = 1'b0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;
    bit          hold_req    = 1'b0;
    int unsigned stall_count = 0;

    list_scoreboard sb = new();

    logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h0000_002A};

    positional_list_engine u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // opcode, position, element
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // ok, data_out, index_out, count_out, is_empty
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // note requests, check results and watch for a stuck handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $realtime, stall_count, sb.pending());
                $display("tb: failure");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    // result side: random stalls, a long hold-off on request
    initial begin : result_sink
        int gap;
        wait (started);
        forever begin
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = recv_burst ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [4:0] pos,
                                input logic [31:0] elem);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {elem, pos, op};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic random_request(input int mode);
        int unsigned cnt;
        int unsigned r;
        int unsigned ins_w;
        int unsigned rem_w;
        logic [2:0]  op;
        logic [4:0]  pos;
        logic [31:0] elem;
        cnt   = sb.list_count();
        ins_w = (mode == 0) ? 55 : (mode == 1) ? 12 : 30;
        rem_w = (mode == 1) ? 35 : 12;
        r     = $urandom_range(0, 99);
        if (r < ins_w) begin
            op = plc_pkg::OP_INSERT;
        end else if (r < ins_w + rem_w) begin
            op = plc_pkg::OP_REMOVE_AT;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20)      op = plc_pkg::OP_REMOVE_VAL;
            else if (r < 40) op = plc_pkg::OP_REPLACE;
            else if (r < 65) op = plc_pkg::OP_FIND;
            else if (r < 94) op = plc_pkg::OP_READ;
            else             op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        // positions mostly in range, some anywhere in the field
        if ($urandom_range(0, 9) == 0)        pos = 5'($urandom_range(0, 31));
        else if (op == plc_pkg::OP_INSERT)    pos = 5'($urandom_range(0, cnt));
        else if (cnt == 0)                    pos = 5'd0;
        else if ($urandom_range(0, 19) == 0)  pos = 5'(cnt);
        else                                  pos = 5'($urandom_range(0, cnt - 1));
        // small value pool gives duplicates, some values copied from the list
        r = $urandom_range(0, 99);
        if ((op == plc_pkg::OP_FIND || op == plc_pkg::OP_REMOVE_VAL) && cnt > 0 && r < 50)
            elem = sb.cells[$urandom_range(0, cnt - 1)];
        else if (r < 75)
            elem = value_pool[$urandom_range(0, 7)];
        else
            elem = $urandom;
        send_request(op, pos, elem);
    endtask

    initial begin : stimulus
        int mode;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        started  = 1'b1;
        @(posedge i_clk);

        // empty list, bad insert position, extremes and duplicates
        send_request(plc_pkg::OP_READ,       5'd0,  32'h0000_0000);
        send_request(plc_pkg::OP_REMOVE_AT,  5'd0,  32'h0000_0000);
        send_request(plc_pkg::OP_REMOVE_VAL, 5'd0,  32'h0000_0000);
        send_request(plc_pkg::OP_FIND,       5'd0,  32'h0000_0000);
        send_request(plc_pkg::OP_INSERT,     5'd1,  32'h1234_5678);
        send_request(plc_pkg::OP_INSERT,     5'd0,  32'h8000_0000);
        send_request(plc_pkg::OP_INSERT,     5'd1,  32'h7FFF_FFFF);
        send_request(plc_pkg::OP_INSERT,     5'd0,  32'hFFFF_FFFF);
        send_request(plc_pkg::OP_INSERT,     5'd3,  32'hFFFF_FFFF);
        send_request(plc_pkg::OP_FIND,       5'd31, 32'hFFFF_FFFF);
        send_request(plc_pkg::OP_REMOVE_VAL, 5'd0,  32'hFFFF_FFFF);
        send_request(plc_pkg::OP_REPLACE,    5'd31, 32'h0BAD_0BAD);
        send_request(plc_pkg::OP_REPLACE,    5'd0,  32'h5555_5555);
        send_request(plc_pkg::OP_READ,       5'd3,  32'h0000_0000);
        send_request(plc_pkg::OP_REMOVE_AT,  5'd1,  32'h0000_0000);
        send_request(OP_SPARE_6,             5'd0,  32'h0000_0000);
        send_request(OP_SPARE_7,             5'd31, 32'hFFFF_FFFF);
        // run into the full list, then work at the top entry
        for (int k = 0; k < plc_pkg::CAPACITY - 1; k++)
            send_request(plc_pkg::OP_INSERT, 5'd0, 32'(k) ^ 32'hAAAA_AAAA);
        send_request(plc_pkg::OP_READ,       5'd15, 32'h0000_0000);
        send_request(plc_pkg::OP_REMOVE_AT,  5'd15, 32'h0000_0000);
        send_request(plc_pkg::OP_INSERT,     5'd15, 32'h0000_7777);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            mode       = $urandom_range(0, 2);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (p == 4 || p == 13) hold_req = 1'b1;
            if (p % 5 == 0) wait_drained();
            repeat (PHASE_LEN) random_request(mode);
        end
        s_valid <= 1'b0;

        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests, %0d results checked, %0d succeeded", sb.requests,
                 sb.checked, sb.succeeded);
        $display("opcode mix %0d/%0d/%0d/%0d/%0d/%0d spare %0d, full-list inserts %0d",
                 sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
                 sb.op_seen[4], sb.op_seen[5], sb.op_seen[6] + sb.op_seen[7],
                 sb.full_hits);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
